### rtl/core/sstc_pkg.sv
// Shared constants, types and helpers of the shift-state charset transcoder.
package sstc_pkg;

    localparam int TABLE_DEPTH = 4096;
    localparam int BIT_SLOTS   = 16;
    localparam int TBL_AW      = $clog2(TABLE_DEPTH);
    localparam int SCAN_AW     = 17;
    localparam int CNT_W       = 13;
    localparam int CODE_W      = 12;
    localparam int SH_W        = 4;
    localparam int IDX_W       = 17;

    localparam logic [SH_W-1:0] MAX_SHIFTS = 4'd9;
    localparam logic [7:0]      TAB_CHAR   = 8'd9;
    localparam logic [7:0]      SPACE_CHAR = 8'd32;

    localparam logic [1:0] FN_WR_IN  = 2'd0;
    localparam logic [1:0] FN_WR_OUT = 2'd1;
    localparam logic [1:0] FN_START  = 2'd2;
    localparam logic [1:0] FN_CONV   = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NUL     = 2'd1;
    localparam logic [1:0] ST_TAB     = 2'd2;
    localparam logic [1:0] ST_NOROUTE = 2'd3;

    localparam logic [2:0] CFG_IN_MAP      = 3'd0;
    localparam logic [2:0] CFG_OUT_MAP     = 3'd1;
    localparam logic [2:0] CFG_IN_GEO      = 3'd2;
    localparam logic [2:0] CFG_OUT_GEO     = 3'd3;
    localparam logic [2:0] CFG_PAD_STYLE   = 3'd4;
    localparam logic [2:0] CFG_START_SHIFT = 3'd5;

    typedef enum logic [1:0] {SM_CHAR, SM_SHIFT, SM_INTER} scan_mode_t;

    typedef struct packed {
        scan_mode_t       mode;
        logic [7:0]       val;
        logic [SH_W-1:0]  pref;
        logic [SH_W-1:0]  excl;
        logic [SH_W-1:0]  inter;
        logic [SH_W-1:0]  base;
        logic [CNT_W-1:0] count;
        logic [SH_W-1:0]  osh;
    } scan_req_t;

    typedef struct packed {
        logic             first_hit;
        logic [CNT_W-1:0] first_code;
        logic [SH_W-1:0]  first_shift;
        logic             last_hit;
        logic [CNT_W-1:0] last_code;
        logic [SH_W-1:0]  last_shift;
    } scan_res_t;

    function automatic logic [12:0] geo_len(input logic [17:0] g);
        return g[12:0];
    endfunction

    function automatic logic [SH_W-1:0] geo_shifts(input logic [17:0] g);
        logic [SH_W-1:0] s;
        s = g[16:13];
        if (s == '0) s = 4'd1;
        if (s > MAX_SHIFTS) s = MAX_SHIFTS;
        return s;
    endfunction

    function automatic logic geo_two(input logic [17:0] g);
        return g[17];
    endfunction

endpackage

### rtl/core/sstc_encode.sv
// Output bit permutation: places code bits and pad bits into the output word.
module sstc_encode import sstc_pkg::*; (
    input  logic [CODE_W-1:0] val,
    input  logic [63:0]       bit_map,
    input  logic              two_byte,
    input  logic              pad_style,
    output logic [15:0]       word
);

    always_comb
    begin
        logic [15:0] v16;
        logic [3:0]  nib;
        int          slots;
        int          pos;
        v16   = {{(16-CODE_W){1'b0}}, val};
        slots = two_byte ? BIT_SLOTS : 8;
        word  = '0;
        for (int i = 0; i < BIT_SLOTS; i++)
        begin
            nib = bit_map[4*i +: 4];
            pos = slots - 1 - i;
            if (i < slots)
            begin
                if (nib >= 4'd12)
                    word[pos[3:0]] = pad_style && (i == 1 || i == 9);
                else
                    word[pos[3:0]] = v16[nib];
            end
        end
    end

endmodule

### rtl/core/sstc_scan.sv
// Output table memory with a sequential search engine over its entries.
module sstc_scan import sstc_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  logic [TBL_AW-1:0] wr_addr,
    input  logic [7:0]        wr_data,
    input  logic              start,
    input  scan_req_t         req,
    output logic              busy,
    output logic              done,
    output scan_res_t         res
);

    logic [7:0]         mem [TABLE_DEPTH];
    logic [7:0]         rdata_reg;
    scan_req_t          req_reg;
    logic               run_reg;
    logic [CNT_W-1:0]   rem_reg;
    logic [SCAN_AW-1:0] addr_reg;
    logic [CNT_W-1:0]   code_reg;
    logic [SH_W-1:0]    shift_reg;
    logic               p_valid_reg;
    logic               p_last_reg;
    logic               p_oor_reg;
    logic [CNT_W-1:0]   p_code_reg;
    logic [SH_W-1:0]    p_shift_reg;
    logic               done_reg;
    scan_res_t          res_reg;
    logic [7:0]         rd_val;
    logic               hit;
    logic               cond;

    // table write and one registered read a cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rdata_reg <= mem[addr_reg[TBL_AW-1:0]];
    end

    always_comb
    begin
        rd_val = p_oor_reg ? 8'd0 : rdata_reg;
        hit    = (rd_val == req_reg.val);
        case (req_reg.mode)
            SM_CHAR:  cond = (req_reg.pref != '0) && (p_shift_reg == req_reg.pref - 4'd1);
            SM_SHIFT: cond = 1'b1;
            SM_INTER: cond = (p_shift_reg != req_reg.excl) &&
                             (p_shift_reg + 4'd1 != req_reg.inter);
            default:  cond = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg     <= 1'b0;
            p_valid_reg <= 1'b0;
            done_reg    <= 1'b0;
            res_reg     <= '0;
        end
        else if (start)
        begin
            req_reg             <= req;
            run_reg             <= (req.count != '0);
            rem_reg             <= req.count;
            addr_reg            <= {{(SCAN_AW-SH_W){1'b0}}, req.base};
            code_reg            <= '0;
            shift_reg           <= '0;
            p_valid_reg         <= 1'b0;
            done_reg            <= (req.count == '0);
            res_reg.first_hit   <= 1'b0;
            res_reg.last_hit    <= 1'b0;
        end
        else
        begin
            done_reg    <= 1'b0;
            p_valid_reg <= run_reg;
            if (run_reg)
            begin
                p_code_reg  <= code_reg;
                p_shift_reg <= shift_reg;
                p_oor_reg   <= (addr_reg >= SCAN_AW'(TABLE_DEPTH));
                p_last_reg  <= (rem_reg == CNT_W'(1));
                rem_reg     <= rem_reg - CNT_W'(1);
                if (rem_reg == CNT_W'(1))
                    run_reg <= 1'b0;
                // advance through the table
                if (req_reg.mode == SM_SHIFT)
                begin
                    addr_reg <= addr_reg + {{(SCAN_AW-SH_W){1'b0}}, req_reg.osh};
                    code_reg <= code_reg + CNT_W'(1);
                end
                else
                begin
                    addr_reg <= addr_reg + SCAN_AW'(1);
                    if (shift_reg == req_reg.osh - 4'd1)
                    begin
                        shift_reg <= '0;
                        code_reg  <= code_reg + CNT_W'(1);
                    end
                    else
                        shift_reg <= shift_reg + 4'd1;
                end
            end
            if (p_valid_reg)
            begin
                if (hit && !res_reg.first_hit)
                begin
                    res_reg.first_hit   <= 1'b1;
                    res_reg.first_code  <= p_code_reg;
                    res_reg.first_shift <= p_shift_reg;
                end
                if (hit && cond)
                begin
                    res_reg.last_hit   <= 1'b1;
                    res_reg.last_code  <= p_code_reg;
                    res_reg.last_shift <= p_shift_reg;
                end
                if (p_last_reg)
                    done_reg <= 1'b1;
            end
        end
    end

    assign busy = run_reg | p_valid_reg;
    assign done = done_reg;
    assign res  = res_reg;

endmodule

### rtl/core/shift_state_charset_transcoder.sv
// Top level of the shift-state charset transcoder: control, input table and result queue.
//
// Converts characters from one table-defined shift-state character set to another
// through Latin-1. Table writes (func 0 and 1) and string starts (func 2) are done
// on acceptance and leave the block idle. A convert (func 3) permutes the input bits
// into a code, reads the input table once, then searches the output table through
// its single read port: each search walks the table one entry a cycle. A plain
// character takes one search over len*shifts entries (capped at 4096); a missing
// tab adds a second; a shift change adds up to nine per-shift searches over len
// entries and two intermediate-shift rounds, so the worst item makes two full-table
// character searches, nine per-shift searches of 8191 codes and two intermediate
// rounds. Results (one to three words, the last flagged by last) pass through a
// four-entry output queue; the next item is taken only once the current item's
// searches are over and its words are all in the queue. Configuration is
// taken at any time on the cfg channel; write it only while the block is idle.
// Tables hold garbage until written.
module shift_state_charset_transcoder import sstc_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  func,
    input  logic [11:0] table_index,
    input  logic [7:0]  table_value,
    input  logic [15:0] char_code,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] out_word,
    output logic [1:0]  status,
    output logic        last
);

    typedef enum logic [3:0] {
        S_IDLE, S_CHECK, S_IREAD, S_LAT, S_FC1, S_FC2, S_ROUTE, S_PICK,
        S_PICKW, S_FS, S_FSW, S_INT, S_INTW, S_KW, S_PUSH
    } state_t;

    state_t state_reg;

    // configuration registers
    logic [63:0]     in_map_reg;
    logic [63:0]     out_map_reg;
    logic [17:0]     in_geo_reg;
    logic [17:0]     out_geo_reg;
    logic            pad_style_reg;
    logic [SH_W-1:0] start_shift_reg;

    // block state
    logic [SH_W-1:0] input_shift_reg;
    logic [SH_W-1:0] output_shift_reg;
    logic            failed_reg;

    // per-item working registers
    logic [CODE_W-1:0] code_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic              idx_oor_reg;
    logic [SH_W-1:0]   ssi_reg;
    logic [SH_W-1:0]   sso_reg;
    logic [7:0]        lat_reg;
    logic [1:0]        st_reg;
    logic [SH_W-1:0]   tgt_reg;
    logic [CODE_W-1:0] ch_reg;
    logic [SH_W-1:0]   j_reg;
    logic [SH_W-1:0]   inter_reg;
    logic [CODE_W-1:0] found_reg;
    logic              tries_reg;

    // staged results of the current item
    logic [CODE_W-1:0] res_val_reg [3];
    logic              res_raw_reg;
    logic [1:0]        res_st_reg;
    logic [1:0]        res_n_reg;
    logic [1:0]        res_idx_reg;

    // output queue
    logic [15:0] q_word_reg [4];
    logic [1:0]  q_st_reg [4];
    logic        q_last_reg [4];
    logic [1:0]  q_wr_reg;
    logic [1:0]  q_rd_reg;
    logic [2:0]  q_cnt_reg;

    // input table
    logic [7:0] in_mem [TABLE_DEPTH];
    logic [7:0] in_rdata_reg;

    // scan unit interface
    logic      scan_start_reg;
    scan_req_t scan_req_reg;
    logic      scan_busy;
    logic      scan_done;
    scan_res_t scan_res;

    logic              in_acc;
    logic              push;
    logic              pop;
    logic              q_full;
    logic [CODE_W-1:0] code_c;
    logic [SH_W-1:0]   ish;
    logic [SH_W-1:0]   osh;
    logic [12:0]       isl;
    logic [12:0]       osl;
    logic [SH_W-1:0]   ssi_c;
    logic [SH_W-1:0]   sso_c;
    logic [CNT_W-1:0]  out_total;
    logic [7:0]        lat_c;
    logic [15:0]       enc_word;
    logic [CNT_W-1:0]  best_code;
    logic [SH_W-1:0]   best_shift;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == S_IDLE);
    assign in_acc    = in_valid && in_ready;
    assign q_full    = (q_cnt_reg == 3'd4);
    assign push      = (state_reg == S_PUSH) && !q_full;
    assign pop       = out_valid && out_ready;

    assign ish = geo_shifts(in_geo_reg);
    assign osh = geo_shifts(out_geo_reg);
    assign isl = geo_len(in_geo_reg);
    assign osl = geo_len(out_geo_reg);

    // input bit permutation
    always_comb
    begin
        logic [15:0] raw;
        logic [15:0] acc;
        logic [3:0]  nib;
        int          slots;
        int          pos;
        raw   = geo_two(in_geo_reg) ? char_code : {8'd0, char_code[7:0]};
        slots = geo_two(in_geo_reg) ? BIT_SLOTS : 8;
        acc   = '0;
        for (int i = 0; i < BIT_SLOTS; i++)
        begin
            nib = in_map_reg[4*i +: 4];
            pos = slots - 1 - i;
            if (i < slots && nib < 4'd12)
                acc[nib] = acc[nib] | raw[pos[3:0]];
        end
        code_c = acc[CODE_W-1:0];
    end

    always_comb
    begin
        logic [16:0] prod;
        ssi_c = input_shift_reg;
        if (ish == 4'd1 || ssi_c == '0)
            ssi_c = 4'd1;
        if (ssi_c > ish)
            ssi_c = ish;
        sso_c = output_shift_reg;
        if (osh == 4'd1)
            sso_c = 4'd1;
        if (sso_c > osh)
            sso_c = '0;
        prod      = 17'(osl * osh);
        out_total = (prod > 17'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH) : prod[CNT_W-1:0];
        lat_c     = idx_oor_reg ? 8'd0 : in_rdata_reg;
        // preferred-shift hit wins, else the lowest hit
        best_code  = scan_res.last_hit ? scan_res.last_code  : scan_res.first_code;
        best_shift = scan_res.last_hit ? scan_res.last_shift : scan_res.first_shift;
    end

    // input table: write on accept, one registered read a cycle
    always_ff @(posedge clk)
    begin
        if (in_acc && func == FN_WR_IN && 32'(table_index) < TABLE_DEPTH)
            in_mem[table_index[TBL_AW-1:0]] <= table_value;
        in_rdata_reg <= in_mem[idx_reg[TBL_AW-1:0]];
    end

    sstc_scan u_scan (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (in_acc && func == FN_WR_OUT && 32'(table_index) < TABLE_DEPTH),
        .wr_addr (table_index[TBL_AW-1:0]),
        .wr_data (table_value),
        .start   (scan_start_reg),
        .req     (scan_req_reg),
        .busy    (scan_busy),
        .done    (scan_done),
        .res     (scan_res)
    );

    sstc_encode u_encode (
        .val       (res_val_reg[res_idx_reg]),
        .bit_map   (out_map_reg),
        .two_byte  (geo_two(out_geo_reg)),
        .pad_style (pad_style_reg),
        .word      (enc_word)
    );

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_map_reg      <= '0;
            out_map_reg     <= '0;
            in_geo_reg      <= 18'd8192;
            out_geo_reg     <= 18'd8192;
            pad_style_reg   <= 1'b0;
            start_shift_reg <= 4'd1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_IN_MAP:      in_map_reg      <= cfg_data;
                CFG_OUT_MAP:     out_map_reg     <= cfg_data;
                CFG_IN_GEO:      in_geo_reg      <= cfg_data[17:0];
                CFG_OUT_GEO:     out_geo_reg     <= cfg_data[17:0];
                CFG_PAD_STYLE:   pad_style_reg   <= cfg_data[0];
                CFG_START_SHIFT: start_shift_reg <= cfg_data[3:0];
                default:         ;
            endcase
        end
    end

    // output queue
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_wr_reg  <= '0;
            q_rd_reg  <= '0;
            q_cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                q_word_reg[q_wr_reg] <= res_raw_reg ? 16'd0 :
                                        (geo_two(out_geo_reg) ? enc_word
                                                              : {8'd0, enc_word[7:0]});
                q_st_reg[q_wr_reg]   <= res_st_reg;
                q_last_reg[q_wr_reg] <= (res_idx_reg == res_n_reg - 2'd1);
                q_wr_reg             <= q_wr_reg + 2'd1;
            end
            if (pop)
                q_rd_reg <= q_rd_reg + 2'd1;
            q_cnt_reg <= q_cnt_reg + {2'd0, push} - {2'd0, pop};
        end
    end

    assign out_valid = (q_cnt_reg != '0);
    assign out_word  = q_word_reg[q_rd_reg];
    assign status    = q_st_reg[q_rd_reg];
    assign last      = q_last_reg[q_rd_reg];

    // conversion sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            input_shift_reg  <= 4'd1;
            output_shift_reg <= '0;
            failed_reg       <= 1'b0;
            scan_start_reg   <= 1'b0;
            res_n_reg        <= 2'd1;
            res_idx_reg      <= '0;
            res_raw_reg      <= 1'b0;
        end
        else
        begin
            scan_start_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (in_acc)
                    begin
                        code_reg <= code_c;
                        if (func == FN_START)
                        begin
                            input_shift_reg  <= start_shift_reg;
                            output_shift_reg <= '0;
                            failed_reg       <= 1'b0;
                        end
                        else if (func == FN_CONV && !failed_reg)
                            state_reg <= S_CHECK;
                    end
                end
                S_CHECK:
                begin
                    res_idx_reg <= '0;
                    res_raw_reg <= 1'b0;
                    if ({1'b0, code_reg} >= isl)
                    begin
                        // code out of range: send NUL
                        res_val_reg[0] <= '0;
                        res_st_reg     <= ST_NUL;
                        res_n_reg      <= 2'd1;
                        state_reg      <= S_PUSH;
                    end
                    else
                    begin
                        ssi_reg     <= ssi_c;
                        idx_reg     <= IDX_W'(code_reg * ish) + IDX_W'(ssi_c) - IDX_W'(1);
                        idx_oor_reg <= (IDX_W'(code_reg * ish) + IDX_W'(ssi_c) - IDX_W'(1))
                                       >= IDX_W'(TABLE_DEPTH);
                        state_reg   <= S_IREAD;
                    end
                end
                S_IREAD:
                    state_reg <= S_LAT;
                S_LAT:
                begin
                    if (ish > 4'd1 && lat_c >= 8'd1 && lat_c <= {4'd0, ish})
                    begin
                        // shift code: change input shift only
                        input_shift_reg <= lat_c[SH_W-1:0];
                        state_reg       <= S_IDLE;
                    end
                    else
                    begin
                        input_shift_reg <= ssi_reg;
                        sso_reg         <= sso_c;
                        lat_reg         <= lat_c;
                        st_reg          <= ST_OK;
                        scan_req_reg    <= '{mode: SM_CHAR, val: lat_c, pref: sso_c,
                                             excl: '0, inter: '0, base: '0,
                                             count: out_total, osh: osh};
                        scan_start_reg  <= 1'b1;
                        state_reg       <= S_FC1;
                    end
                end
                S_FC1, S_FC2:
                begin
                    if (scan_done)
                    begin
                        if (scan_res.first_hit)
                        begin
                            tgt_reg   <= best_shift;
                            ch_reg    <= best_code[CODE_W-1:0];
                            state_reg <= S_ROUTE;
                        end
                        else if (state_reg == S_FC1 && lat_reg == TAB_CHAR)
                        begin
                            // missing tab: look for a space
                            st_reg           <= ST_TAB;
                            scan_req_reg.val <= SPACE_CHAR;
                            scan_start_reg   <= 1'b1;
                            state_reg        <= S_FC2;
                        end
                        else
                        begin
                            res_val_reg[0] <= '0;
                            res_st_reg     <= ST_NUL;
                            res_n_reg      <= 2'd1;
                            state_reg      <= S_PUSH;
                        end
                    end
                end
                S_ROUTE:
                begin
                    if (sso_reg != '0 && tgt_reg == sso_reg - 4'd1)
                    begin
                        output_shift_reg <= sso_reg;
                        res_val_reg[0]   <= ch_reg;
                        res_st_reg       <= st_reg;
                        res_n_reg        <= 2'd1;
                        state_reg        <= S_PUSH;
                    end
                    else if (sso_reg == '0)
                    begin
                        j_reg     <= osh;
                        state_reg <= S_PICK;
                    end
                    else
                        state_reg <= S_FS;
                end
                S_PICK:
                begin
                    // guess the current output shift: highest shift lacking the target code
                    if (j_reg == '0)
                    begin
                        sso_reg   <= (tgt_reg == '0) ? osh : tgt_reg;
                        state_reg <= S_FS;
                    end
                    else if (j_reg - 4'd1 == tgt_reg)
                        j_reg <= j_reg - 4'd1;
                    else
                    begin
                        scan_req_reg   <= '{mode: SM_SHIFT, val: {4'd0, tgt_reg} + 8'd1,
                                            pref: '0, excl: '0, inter: '0,
                                            base: j_reg - 4'd1, count: osl, osh: osh};
                        scan_start_reg <= 1'b1;
                        state_reg      <= S_PICKW;
                    end
                end
                S_PICKW:
                begin
                    if (scan_done)
                    begin
                        if (!scan_res.last_hit)
                        begin
                            sso_reg   <= j_reg;
                            state_reg <= S_FS;
                        end
                        else
                        begin
                            j_reg     <= j_reg - 4'd1;
                            state_reg <= S_PICK;
                        end
                    end
                end
                S_FS:
                begin
                    scan_req_reg   <= '{mode: SM_SHIFT, val: {4'd0, tgt_reg} + 8'd1,
                                        pref: '0, excl: '0, inter: '0,
                                        base: sso_reg - 4'd1, count: osl, osh: osh};
                    scan_start_reg <= 1'b1;
                    state_reg      <= S_FSW;
                end
                S_FSW:
                begin
                    if (scan_done)
                    begin
                        if (scan_res.last_hit)
                        begin
                            res_val_reg[0]   <= scan_res.last_code[CODE_W-1:0];
                            res_val_reg[1]   <= ch_reg;
                            res_st_reg       <= st_reg;
                            res_n_reg        <= 2'd2;
                            output_shift_reg <= tgt_reg + 4'd1;
                            state_reg        <= S_PUSH;
                        end
                        else
                        begin
                            inter_reg <= '0;
                            tries_reg <= 1'b0;
                            state_reg <= S_INT;
                        end
                    end
                end
                S_INT:
                begin
                    scan_req_reg   <= '{mode: SM_INTER, val: {4'd0, tgt_reg} + 8'd1,
                                        pref: '0, excl: tgt_reg, inter: inter_reg,
                                        base: '0, count: out_total, osh: osh};
                    scan_start_reg <= 1'b1;
                    state_reg      <= S_INTW;
                end
                S_INTW:
                begin
                    if (scan_done)
                    begin
                        if (scan_res.last_hit)
                        begin
                            inter_reg      <= scan_res.last_shift + 4'd1;
                            found_reg      <= scan_res.last_code[CODE_W-1:0];
                            scan_req_reg   <= '{mode: SM_SHIFT,
                                                val: {4'd0, scan_res.last_shift} + 8'd1,
                                                pref: '0, excl: '0, inter: '0,
                                                base: sso_reg - 4'd1, count: osl,
                                                osh: osh};
                            scan_start_reg <= 1'b1;
                            state_reg      <= S_KW;
                        end
                        else
                        begin
                            failed_reg  <= 1'b1;
                            res_raw_reg <= 1'b1;
                            res_st_reg  <= ST_NOROUTE;
                            res_n_reg   <= 2'd1;
                            state_reg   <= S_PUSH;
                        end
                    end
                end
                S_KW:
                begin
                    if (scan_done)
                    begin
                        if (scan_res.last_hit)
                        begin
                            res_val_reg[0]   <= scan_res.last_code[CODE_W-1:0];
                            res_val_reg[1]   <= found_reg;
                            res_val_reg[2]   <= ch_reg;
                            res_st_reg       <= st_reg;
                            res_n_reg        <= 2'd3;
                            output_shift_reg <= tgt_reg + 4'd1;
                            state_reg        <= S_PUSH;
                        end
                        else if (tries_reg)
                        begin
                            failed_reg  <= 1'b1;
                            res_raw_reg <= 1'b1;
                            res_st_reg  <= ST_NOROUTE;
                            res_n_reg   <= 2'd1;
                            state_reg   <= S_PUSH;
                        end
                        else
                        begin
                            tries_reg <= 1'b1;
                            state_reg <= S_INT;
                        end
                    end
                end
                S_PUSH:
                begin
                    if (push)
                    begin
                        res_idx_reg <= res_idx_reg + 2'd1;
                        if (res_idx_reg == res_n_reg - 2'd1)
                            state_reg <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    // never push into a full queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PUSH && q_full) |=> (q_cnt_reg == 3'd4 || q_cnt_reg == 3'd3))
        else $error("output queue overflow");

    // a scan is only started while the search unit is free
    a_scan_free: assert property (@(posedge clk) disable iff (!rst_n)
        scan_start_reg |-> !scan_busy)
        else $error("scan started while busy");

    // output shift stays within the shift range
    a_oshift_range: assert property (@(posedge clk) disable iff (!rst_n)
        output_shift_reg <= MAX_SHIFTS)
        else $error("output shift out of range");

    // a convert after a routing failure produces nothing
    a_failed_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && func == FN_CONV && failed_reg) |=> (state_reg == S_IDLE))
        else $error("convert not dropped after failure");

endmodule

### verif/tb_shift_state_charset_transcoder.sv
// Self-checking testbench for the shift-state charset transcoder.
`timescale 1ns / 1ps

module tb_shift_state_charset_transcoder;
    import sstc_pkg::*;

    // Quiet time after the last expected word: a search over a small table
    // finishes in well under this, even for items that produce no word.
    localparam int SETTLE_CYC = 20000;
    localparam int NUM_PHASES = 8;
    // Entries a random geometry can read: four codes by nine shifts on the
    // input side, three codes by nine shifts on the output side.
    localparam int IN_FILL    = 36;
    localparam int OUT_FILL   = 27;

    typedef struct {
        logic [15:0] word;
        logic [1:0]  st;
        logic        lst;
    } out_word_t;

    typedef struct {
        logic [1:0]  fn;
        int          ti;
        int          tv;
        int          cc;
        bit          typed;
        logic [15:0] word;
        logic [1:0]  st;
    } dir_row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [63:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  func;
    logic [11:0] table_index;
    logic [7:0]  table_value;
    logic [15:0] char_code;
    logic        out_valid;
    logic        out_ready;
    logic [15:0] out_word;
    logic [1:0]  status;
    logic        last;

    // Words still owed by the block, oldest first.
    out_word_t   pending_words[$];
    int          errors;
    int          send_idle_pct;
    int          recv_stall_pct;

    // Shadow copy of the block's tables, registers and shift state.
    logic [7:0]  sh_in_tab[TABLE_DEPTH];
    logic [7:0]  sh_out_tab[TABLE_DEPTH];
    logic [63:0] sh_in_map;
    logic [63:0] sh_out_map;
    logic [17:0] sh_in_geo;
    logic [17:0] sh_out_geo;
    logic        sh_pad;
    logic [3:0]  sh_start;
    int unsigned cur_in_shift;
    int unsigned cur_out_shift;
    bit          route_lost;

    // Directed rows. Expected words are typed in only for the NUL cases.
    dir_row_t dir_tab[27] = '{
        // after reset: zero-length set, every code is out of range
        '{FN_CONV,    0,    0, 'h00FF, 1, 16'h0000, ST_NUL},
        '{FN_START,   0,    0,      0, 0, 16'h0000, ST_OK},
        '{FN_CONV,    0,    0, 'hFF00, 1, 16'h0000, ST_NUL},
        // input set: 4 codes, 2 shifts (directed registers are written here)
        '{FN_WR_IN,   0,  "a",      0, 0, 16'h0000, ST_OK},
        '{FN_WR_IN,   1,    9,      0, 0, 16'h0000, ST_OK},
        '{FN_WR_IN,   2,    2,      0, 0, 16'h0000, ST_OK},
        '{FN_WR_IN,   3,    1,      0, 0, 16'h0000, ST_OK},
        '{FN_WR_IN,   4,  "l",      0, 0, 16'h0000, ST_OK},
        '{FN_WR_IN,   5, 'h41,      0, 0, 16'h0000, ST_OK},
        '{FN_WR_IN,   6,  200,      0, 0, 16'h0000, ST_OK},
        '{FN_WR_IN,   7,   32,      0, 0, 16'h0000, ST_OK},
        // output set: same shape, shift codes on code 1
        '{FN_WR_OUT,  0,  "a",      0, 0, 16'h0000, ST_OK},
        '{FN_WR_OUT,  1,  "l",      0, 0, 16'h0000, ST_OK},
        '{FN_WR_OUT,  2,    2,      0, 0, 16'h0000, ST_OK},
        '{FN_WR_OUT,  3,    1,      0, 0, 16'h0000, ST_OK},
        '{FN_WR_OUT,  4, 'h41,      0, 0, 16'h0000, ST_OK},
        '{FN_WR_OUT,  5,   32,      0, 0, 16'h0000, ST_OK},
        '{FN_WR_OUT,  6,    0,      0, 0, 16'h0000, ST_OK},
        '{FN_WR_OUT,  7,    0,      0, 0, 16'h0000, ST_OK},
        '{FN_START,   0,    0,      0, 0, 16'h0000, ST_OK},
        // first character: no output state yet, so a shift word leads
        '{FN_CONV,    0,    0,      0, 0, 16'h0000, ST_OK},
        // untranslatable character and out-of-range codes become NUL
        '{FN_CONV,    0,    0,      3, 1, 16'h0000, ST_NUL},
        '{FN_CONV,    0,    0,      5, 1, 16'h0000, ST_NUL},
        // input shift code: no word
        '{FN_CONV,    0,    0,      1, 0, 16'h0000, ST_OK},
        // tab missing from the output set: sent as a space
        '{FN_CONV,    0,    0,      0, 0, 16'h0000, ST_OK},
        '{FN_CONV,    0,    0,      2, 0, 16'h0000, ST_OK},
        '{FN_CONV,    0,    0, 'hFFFF, 1, 16'h0000, ST_NUL}
    };

    shift_state_charset_transcoder u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .func        (func),
        .table_index (table_index),
        .table_value (table_value),
        .char_code   (char_code),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_word    (out_word),
        .status      (status),
        .last        (last)
    );

    always #5 clk = ~clk;

    // ---------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------

    function automatic int unsigned shift_count(input logic [17:0] g);
        int unsigned s;
        s = g[16:13];
        if (s < 1) s = 1;
        if (s > 9) s = 9;
        return s;
    endfunction

    function automatic int unsigned out_span();
        int unsigned n;
        n = sh_out_geo[12:0] * shift_count(sh_out_geo);
        return (n > TABLE_DEPTH) ? TABLE_DEPTH : n;
    endfunction

    function automatic int unsigned out_entry(input int unsigned i);
        return (i < TABLE_DEPTH) ? sh_out_tab[i] : 0;
    endfunction

    function automatic int unsigned in_entry(input int unsigned i);
        return (i < TABLE_DEPTH) ? sh_in_tab[i] : 0;
    endfunction

    // Scatter a code over the output bit slots, slot 0 being the MSB.
    function automatic logic [15:0] pack_code(input int unsigned v);
        int unsigned slots, w, nib, pos, i;
        slots = sh_out_geo[17] ? 16 : 8;
        w = 0;
        for (i = 0; i < slots; i++)
        begin
            nib = (sh_out_map >> (4 * i)) & 15;
            pos = slots - 1 - i;
            if (nib >= 12)
            begin
                if (sh_pad && (i == 1 || i == 9)) w |= 1 << pos;
            end
            else
                w |= ((v >> nib) & 1) << pos;
        end
        return sh_out_geo[17] ? w[15:0] : {8'h00, w[7:0]};
    endfunction

    function automatic void owe(input logic [15:0] w, input int unsigned st,
                                input bit lst);
        out_word_t e;
        e.word = w;
        e.st   = st[1:0];
        e.lst  = lst;
        pending_words.push_back(e);
    endfunction

    // Highest match in the preferred shift, else the lowest match.
    function automatic int locate_char(input int unsigned v, input int unsigned pref,
                                       input int unsigned sh);
        int best, i;
        best = -1;
        for (i = out_span() - 1; i >= 0; i--)
            if (out_entry(i) == v && (best < 0 || (best % sh) + 1 != pref))
                best = i;
        return best;
    endfunction

    // Highest code in shift s carrying value v.
    function automatic int code_in_shift(input int unsigned s, input int unsigned v);
        int unsigned sh;
        int i;
        sh = shift_count(sh_out_geo);
        for (i = sh_out_geo[12:0] - 1; i >= 0; i--)
            if (out_entry(i * sh + s - 1) == v) return i;
        return -1;
    endfunction

    function automatic void transcode_char(input logic [15:0] cc);
        int unsigned ilen, ish, osh, raw, slots, code, i, nib;
        int unsigned ssi, sso, lat, st, tgt, ch, j, pick, inter, tries;
        int idx, c, found, k, n;
        ilen  = sh_in_geo[12:0];
        ish   = shift_count(sh_in_geo);
        osh   = shift_count(sh_out_geo);
        raw   = sh_in_geo[17] ? cc : cc[7:0];
        slots = sh_in_geo[17] ? 16 : 8;
        code  = 0;
        for (i = 0; i < slots; i++)
        begin
            nib = (sh_in_map >> (4 * i)) & 15;
            if (nib < 12) code |= ((raw >> (slots - 1 - i)) & 1) << nib;
        end
        if (code >= ilen)
        begin
            owe(pack_code(0), ST_NUL, 1);
            return;
        end
        ssi = cur_in_shift;
        if (ish == 1 || ssi < 1) ssi = 1;
        if (ssi > ish) ssi = ish;
        lat = in_entry(code * ish + ssi - 1);
        if (ish > 1 && lat >= 1 && lat <= ish)
        begin
            cur_in_shift = lat;
            return;
        end
        cur_in_shift = ssi;
        sso = cur_out_shift;
        if (osh == 1) sso = 1;
        if (sso > osh) sso = 0;
        st = ST_OK;
        idx = locate_char(lat, sso, osh);
        if (idx < 0 && lat == TAB_CHAR)
        begin
            st = ST_TAB;
            idx = locate_char(SPACE_CHAR, sso, osh);
        end
        if (idx < 0)
        begin
            owe(pack_code(0), ST_NUL, 1);
            return;
        end
        tgt = idx % osh;
        ch  = idx / osh;
        if (sso >= 1 && tgt == sso - 1)
        begin
            cur_out_shift = sso;
            owe(pack_code(ch), st, 1);
            return;
        end
        if (sso == 0)
        begin
            // guess the shift we are in: one that has no code for the target
            pick = 0;
            for (j = osh; j >= 1; j--)
            begin
                if (j - 1 == tgt) continue;
                if (code_in_shift(j, tgt + 1) < 0)
                begin
                    pick = j;
                    break;
                end
            end
            sso = pick ? pick : tgt;
            if (sso == 0) sso = osh;
        end
        c = code_in_shift(sso, tgt + 1);
        if (c >= 0)
        begin
            owe(pack_code(c), st, 0);
            owe(pack_code(ch), st, 1);
            cur_out_shift = tgt + 1;
            return;
        end
        inter = 0;
        for (tries = 0; tries < 2; tries++)
        begin
            found = -1;
            for (n = out_span() - 1; n >= 0; n--)
                if (out_entry(n) == tgt + 1 && n % osh != tgt && n % osh + 1 != inter)
                begin
                    found = n;
                    break;
                end
            if (found < 0) break;
            inter = found % osh + 1;
            k = code_in_shift(sso, inter);
            if (k >= 0)
            begin
                owe(pack_code(k), st, 0);
                owe(pack_code(found / osh), st, 0);
                owe(pack_code(ch), st, 1);
                cur_out_shift = tgt + 1;
                return;
            end
        end
        route_lost = 1;
        owe(16'h0000, ST_NOROUTE, 1);
    endfunction

    function automatic void predict_item(input logic [1:0] fn, input logic [11:0] ti,
                                         input logic [7:0] tv, input logic [15:0] cc);
        case (fn)
            FN_WR_IN:  sh_in_tab[ti] = tv;
            FN_WR_OUT: sh_out_tab[ti] = tv;
            FN_START:
            begin
                cur_in_shift  = sh_start;
                cur_out_shift = 0;
                route_lost    = 0;
            end
            default:
                if (!route_lost) transcode_char(cc);
        endcase
    endfunction

    // ---------------------------------------------------------------
    // Drivers
    // ---------------------------------------------------------------

    // Write one register; call only with the block idle, from a falling edge.
    task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        case (idx)
            CFG_IN_MAP:      sh_in_map  = val;
            CFG_OUT_MAP:     sh_out_map = val;
            CFG_IN_GEO:      sh_in_geo  = val[17:0];
            CFG_OUT_GEO:     sh_out_geo = val[17:0];
            CFG_PAD_STYLE:   sh_pad     = val[0];
            CFG_START_SHIFT: sh_start   = val[3:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Offer one item from a falling edge; return at the falling edge after
    // acceptance with valid still high, so back-to-back items need no gap.
    task automatic send_item(input logic [1:0] fn, input logic [11:0] ti,
                             input logic [7:0] tv, input logic [15:0] cc);
        int gap;
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            gap = $urandom_range(1, 6);
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid    = 1'b1;
        func        = fn;
        table_index = ti;
        table_value = tv;
        char_code   = cc;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        predict_item(fn, ti, tv, cc);
        @(negedge clk);
    endtask

    // Hold the sender until every owed word has come and the block is quiet.
    task automatic drain();
        in_valid = 1'b0;
        while (pending_words.size() != 0) @(negedge clk);
        repeat (SETTLE_CYC) @(negedge clk);
    endtask

    function automatic logic [7:0] table_byte(input int unsigned nsh);
        case ($urandom_range(7))
            0, 1: return $urandom_range(1, nsh + 1);
            2:    return TAB_CHAR;
            3:    return SPACE_CHAR;
            4:    return "a";
            5:    return "l";
            6:    return 8'h00;
            default: return $urandom_range(255);
        endcase
    endfunction

    // Receiver: stall at the configured rate, decided on the falling edge.
    always @(negedge clk)
        out_ready = (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);

    // Checker: compare each accepted word with the oldest one owed.
    always @(posedge clk)
    begin
        out_word_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_words.size() == 0)
            begin
                $display("%0t: unexpected word %h status %0d last %0d",
                         $time, out_word, status, last);
                errors++;
            end
            else
            begin
                e = pending_words.pop_front();
                if (out_word !== e.word)
                begin
                    $display("%0t: out_word expected %h actual %h", $time, e.word, out_word);
                    errors++;
                end
                if (status !== e.st)
                begin
                    $display("%0t: status expected %0d actual %0d", $time, e.st, status);
                    errors++;
                end
                if (last !== e.lst)
                begin
                    $display("%0t: last expected %0d actual %0d", $time, e.lst, last);
                    errors++;
                end
            end
        end
    end

    // Guard against a hung block.
    initial
    begin
        #60ms;
        $display("tb_shift_state_charset_transcoder NOT OK");
        $finish;
    end

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------
    initial
    begin
        int ph, r, n, i, cb, ncodes, ish, osh, in_region, out_region;
        logic [63:0] imap, omap;
        logic [17:0] igeo, ogeo;
        logic [3:0]  nib;
        int pos;

        clk = 1'b0;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        func = FN_START;
        table_index = '0;
        table_value = '0;
        char_code = '0;
        out_ready = 1'b1;
        errors = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;

        // Predictor state after reset.
        sh_in_map = '0;
        sh_out_map = '0;
        sh_in_geo = 18'd8192;
        sh_out_geo = 18'd8192;
        sh_pad = 1'b0;
        sh_start = 4'd1;
        cur_in_shift = 1;
        cur_out_shift = 0;
        route_lost = 0;

        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed part: walk the table, swapping in typed expectations.
        for (r = 0; r < 27; r++)
        begin
            if (r == 3)
            begin
                drain();
                write_reg(CFG_IN_MAP, 64'hFFFF_FFFF_0123_4567);
                write_reg(CFG_OUT_MAP, 64'hFFFF_FFFF_0123_4567);
                write_reg(CFG_IN_GEO, (2 << 13) | 4);
                write_reg(CFG_OUT_GEO, (2 << 13) | 4);
                write_reg(CFG_PAD_STYLE, 0);
                write_reg(CFG_START_SHIFT, 1);
            end
            if (dir_tab[r].typed)
            begin
                // let earlier words leave so the typed word can replace the predicted one
                in_valid = 1'b0;
                while (pending_words.size() != 0) @(negedge clk);
            end
            n = pending_words.size();
            send_item(dir_tab[r].fn, dir_tab[r].ti, dir_tab[r].tv, dir_tab[r].cc);
            if (dir_tab[r].typed)
            begin
                while (pending_words.size() > n) void'(pending_words.pop_back());
                owe(dir_tab[r].word, dir_tab[r].st, 1);
            end
        end

        // Fill, once, every entry that any random geometry below can read.
        for (i = 0; i < IN_FILL; i++)
            send_item(FN_WR_IN, 12'(i), table_byte(9), 16'($urandom));
        for (i = 0; i < OUT_FILL; i++)
            send_item(FN_WR_OUT, 12'(i), table_byte(9), 16'($urandom));

        // Random phases: new registers each time, with the idle mix rotating
        // through none, sender, receiver and both.
        for (ph = 0; ph < NUM_PHASES; ph++)
        begin
            drain();
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 66; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 66; end
                default: begin send_idle_pct = 25; recv_stall_pct = 25; end
            endcase

            cb = $urandom_range(1, 2);
            imap = '0;
            for (pos = 0; pos < 16; pos++)
            begin
                nib = ($urandom_range(2) == 0) ? 4'(12 + $urandom_range(3))
                                               : 4'($urandom_range(cb - 1));
                imap[4*pos +: 4] = nib;
            end
            if (ph == 5) imap = '1;     // every slot don't care: code 0 only
            omap = {$urandom, $urandom};
            if (ph == 1) omap = '1;     // every slot padded

            igeo = {1'($urandom_range(1)), 4'($urandom_range(15)),
                    13'($urandom_range(1, 1 << cb))};
            if (ph == 3) igeo[12:0] = 13'h1FFF;
            if (ph == 6) igeo[12:0] = 13'd0;
            ogeo = {1'($urandom_range(1)), 4'($urandom_range(15)),
                    13'($urandom_range(2, 3))};
            if (ph == 2) ogeo[16:13] = 4'd0;
            if (ph == 3) ogeo[16:13] = 4'd15;
            if (ph == 4) ogeo[16:13] = 4'd9;

            write_reg(CFG_IN_MAP, imap);
            write_reg(CFG_OUT_MAP, omap);
            write_reg(CFG_IN_GEO, igeo);
            write_reg(CFG_OUT_GEO, ogeo);
            write_reg(CFG_PAD_STYLE, $urandom_range(1));
            write_reg(CFG_START_SHIFT, $urandom_range(15));

            ish = shift_count(igeo);
            osh = shift_count(ogeo);
            ncodes = 1 << cb;
            in_region = ncodes * ish;
            out_region = out_span();
            if ($urandom_range(1)) send_item(FN_START, $urandom, $urandom, $urandom);

            // Mostly characters, with string starts and table rewrites mixed in.
            n = 3;
            for (i = 0; i < n; i++)
            begin
                r = $urandom_range(9);
                if (r == 0)
                    send_item(FN_START, $urandom, $urandom, $urandom);
                else if (r == 1)
                    send_item(FN_WR_IN, $urandom_range(in_region - 1), table_byte(ish),
                              $urandom);
                else if (r == 2)
                    send_item(FN_WR_OUT, $urandom_range(out_region - 1), table_byte(osh),
                              $urandom);
                else
                    send_item(FN_CONV, $urandom, $urandom, $urandom);
            end
        end

        drain();
        if (errors == 0)
            $display("tb_shift_state_charset_transcoder OK");
        else
            $display("tb_shift_state_charset_transcoder NOT OK");
        $finish;
    end

endmodule

### filelist.f
rtl/core/sstc_pkg.sv
rtl/core/sstc_encode.sv
rtl/core/sstc_scan.sv
rtl/core/shift_state_charset_transcoder.sv
verif/tb_shift_state_charset_transcoder.sv
